FILE: hdl/crw_pkg.sv
// ---------------------------------------------------------------------------
// crw_pkg: shared types and constants for the chunk receive window
// Holds command and status codes, the queued request layout, the response
// layout and the bitmap row search used by the receive tracker.
// ---------------------------------------------------------------------------
package crw_pkg;

   // Default session size in packets
   localparam int PACKETS_DEF = 512;

   // Timeout register value after reset
   localparam logic [15:0] TIMEOUT_RESET = 16'd8;

   // Received bitmap is kept in rows of this many bits
   localparam int ROW_W  = 32;
   localparam int ROW_LW = $clog2(ROW_W);

   // Depth of the request and response queues
   localparam int QUEUE_DEPTH = 2;

   // Request command codes
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_DATA  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_STALE      = 3'd1,
      ST_NO_SESSION = 3'd2,
      ST_RANGE      = 3'd3,
      ST_BUSY       = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      K_START,
      K_DATA,
      K_TICK,
      K_NONE
   } kind_type;

   // Classified request as it waits between front and back
   typedef struct packed {
      kind_type    kind;
      logic        out_of_range;
      logic [7:0]  peer;
      logic [11:0] chunk_index;
      logic [11:0] seq_num;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic        emit_ack;
      logic [10:0] ack_num;
      logic        chunk_done;
      logic        timed_out;
      logic [11:0] session_chunk;
   } rsp_type;

   // Lowest set bit of a row: {found, index}
   function automatic logic [ROW_LW:0] first_one(input logic [ROW_W-1:0] v);
      logic [ROW_LW:0] res;
      res = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            res = {1'b1, ROW_LW'(i)};
         end
      end
      return res;
   endfunction

endpackage

FILE: hdl/crw_fifo.sv
// ---------------------------------------------------------------------------
// crw_fifo: small register queue
// Holds up to DEPTH entries of WIDTH bits; the oldest entry is shown on
// data_out while empty is low. DEPTH must be a power of two.
// ---------------------------------------------------------------------------
module crw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign data_out = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

FILE: hdl/crw_front.sv
// ---------------------------------------------------------------------------
// crw_front: request intake
// Decodes the command of each incoming request, flags sequence numbers past
// the session size and pushes the classified request into the queue.
// ---------------------------------------------------------------------------
module crw_front #(
   parameter int PACKETS = crw_pkg::PACKETS_DEF
) (
   input  logic              req_push,
   input  logic [1:0]        req_cmd,
   input  logic [7:0]        req_peer,
   input  logic [11:0]       req_chunk_index,
   input  logic [11:0]       req_seq_num,
   output logic              req_full,
   output logic              q_push,
   output crw_pkg::item_type q_item,
   input  logic              q_full
);

   import crw_pkg::*;

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   // Classify the request
   always_comb begin
      unique case (req_cmd)
         CMD_START: q_item.kind = K_START;
         CMD_DATA:  q_item.kind = K_DATA;
         CMD_TICK:  q_item.kind = K_TICK;
         default:   q_item.kind = K_NONE;
      endcase
      q_item.out_of_range = (req_seq_num >= 12'(PACKETS));
      q_item.peer         = req_peer;
      q_item.chunk_index  = req_chunk_index;
      q_item.seq_num      = req_seq_num;
   end

endmodule

FILE: hdl/crw_back.sv
// ---------------------------------------------------------------------------
// crw_back: session tracker
// Executes classified requests against the session state: binds sessions,
// marks packets in the row-organized bitmap memory, walks next-expected past
// received runs one row per cycle, and counts the timeout down on ticks.
// ---------------------------------------------------------------------------
module crw_back #(
   parameter int PACKETS = crw_pkg::PACKETS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_timeout_ticks,
   input  crw_pkg::item_type in_item,
   input  logic              in_empty,
   output logic              in_pop,
   input  logic              out_full,
   output logic              out_push,
   output crw_pkg::rsp_type  out_rsp
);

   import crw_pkg::*;

   localparam int ROWS = (PACKETS + ROW_W - 1) / ROW_W;
   localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int NW   = $clog2(PACKETS + 1);
   localparam int CW   = RAW + ROW_LW + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MARK,
      S_SCAN
   } state_type;

   state_type         state_ff, state_in;
   logic              active_ff, active_in;
   logic [7:0]        peer_ff, peer_in;
   logic [11:0]       chunk_ff, chunk_in;
   logic [NW-1:0]     next_ff, next_in;
   logic [NW-1:0]     missing_ff, missing_in;
   logic [15:0]       tleft_ff, tleft_in;
   logic [15:0]       tticks_ff, tticks_in;
   logic [ROWS-1:0]   row_valid_ff, row_valid_in;
   logic              done_ff, done_in;
   logic [RAW-1:0]    row_ff, row_in;
   logic [ROW_LW-1:0] off_ff, off_in;
   logic              adv_ff, adv_in;

   // Bitmap memory, one row per entry
   logic [ROW_W-1:0]  map_mem [ROWS];
   logic [ROW_W-1:0]  rd_data_ff;
   logic              rd_vld_ff;
   logic [RAW-1:0]    rd_addr;
   logic              mem_we;
   logic [ROW_W-1:0]  wr_data;

   logic [ROW_W-1:0]  cur_row, new_row, scan_row, zeros;
   logic [ROW_LW-1:0] scan_off;
   logic [ROW_LW:0]   hit;
   logic              was_set;
   logic [RAW:0]      nrow_ext;
   logic [CW-1:0]     cand;
   logic              past_end;
   logic [NW-1:0]     cand_next;

   assign csr_ready = 1'b1;

   // Row search: first missing packet at or above the offset
   always_comb begin
      cur_row  = rd_vld_ff ? rd_data_ff : '0;
      was_set  = cur_row[off_ff];
      new_row  = cur_row | (ROW_W'(1) << off_ff);
      scan_row = (state_ff == S_MARK) ? new_row : cur_row;
      scan_off = (state_ff == S_MARK) ? off_ff : '0;
      zeros    = ~scan_row & ({ROW_W{1'b1}} << scan_off);
      hit      = first_one(zeros);
      nrow_ext = {1'b0, row_ff} + 1'b1;
      cand     = hit[ROW_LW] ? {1'b0, row_ff, hit[ROW_LW-1:0]} : {nrow_ext, ROW_LW'(0)};
      past_end = (cand >= CW'(PACKETS));
      cand_next = past_end ? NW'(PACKETS) : NW'(cand);
   end

   // Execute requests
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      peer_in      = peer_ff;
      chunk_in     = chunk_ff;
      next_in      = next_ff;
      missing_in   = missing_ff;
      tleft_in     = tleft_ff;
      tticks_in    = (csr_valid && csr_ready) ? csr_timeout_ticks : tticks_ff;
      row_valid_in = row_valid_ff;
      done_in      = done_ff;
      row_in       = row_ff;
      off_in       = off_ff;
      adv_in       = adv_ff;
      in_pop       = 1'b0;
      out_push     = 1'b0;
      rd_addr      = in_item.seq_num[ROW_LW +: RAW];
      mem_we       = 1'b0;
      wr_data      = new_row;
      out_rsp.status        = ST_OK;
      out_rsp.emit_ack      = 1'b0;
      out_rsp.ack_num       = 11'(next_ff);
      out_rsp.chunk_done    = 1'b0;
      out_rsp.timed_out     = 1'b0;
      out_rsp.session_chunk = chunk_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (!in_empty && !out_full) begin
               in_pop = 1'b1;
               unique case (in_item.kind)
                  K_START: begin
                     out_push = 1'b1;
                     if (active_ff) begin
                        out_rsp.status = ST_BUSY;
                     end else begin
                        peer_in      = in_item.peer;
                        chunk_in     = in_item.chunk_index;
                        row_valid_in = '0;
                        missing_in   = NW'(PACKETS);
                        next_in      = '0;
                        tleft_in     = tticks_ff;
                        active_in    = 1'b1;
                        out_rsp.ack_num       = '0;
                        out_rsp.session_chunk = in_item.chunk_index;
                     end
                  end
                  K_DATA: begin
                     if (!active_ff || in_item.peer != peer_ff) begin
                        out_push       = 1'b1;
                        out_rsp.status = ST_NO_SESSION;
                     end else if (in_item.seq_num < 12'(next_ff)) begin
                        out_push       = 1'b1;
                        out_rsp.status = ST_STALE;
                     end else if (in_item.out_of_range) begin
                        out_push       = 1'b1;
                        out_rsp.status = ST_RANGE;
                     end else begin
                        // Fetch the packet's row, mark it next cycle
                        in_pop   = 1'b1;
                        row_in   = in_item.seq_num[ROW_LW +: RAW];
                        off_in   = in_item.seq_num[ROW_LW-1:0];
                        adv_in   = (in_item.seq_num == 12'(next_ff));
                        tleft_in = tticks_ff;
                        state_in = S_MARK;
                     end
                  end
                  K_TICK: begin
                     out_push = 1'b1;
                     if (active_ff && tleft_ff != '0) begin
                        tleft_in = tleft_ff - 1'b1;
                        if (tleft_ff == 16'd1) begin
                           active_in         = 1'b0;
                           out_rsp.timed_out = 1'b1;
                        end
                     end
                  end
                  default: begin
                     out_push = 1'b1;
                  end
               endcase
            end
         end

         S_MARK: begin
            // Set the packet bit and update the missing count
            mem_we                = 1'b1;
            row_valid_in[row_ff]  = 1'b1;
            if (!was_set && missing_ff != '0) begin
               missing_in = missing_ff - 1'b1;
            end
            done_in = (missing_in == '0);
            if (done_in) begin
               active_in = 1'b0;
            end
            out_rsp.emit_ack   = 1'b1;
            out_rsp.chunk_done = done_in;
            if (!adv_ff) begin
               out_push = 1'b1;
               state_in = S_IDLE;
            end else if (hit[ROW_LW] || past_end) begin
               next_in          = cand_next;
               out_rsp.ack_num  = 11'(cand_next);
               out_push         = 1'b1;
               state_in         = S_IDLE;
            end else begin
               row_in   = nrow_ext[RAW-1:0];
               rd_addr  = nrow_ext[RAW-1:0];
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            // Walk the received run one row at a time
            out_rsp.emit_ack   = 1'b1;
            out_rsp.chunk_done = done_ff;
            if (hit[ROW_LW] || past_end) begin
               next_in         = cand_next;
               out_rsp.ack_num = 11'(cand_next);
               out_push        = 1'b1;
               state_in        = S_IDLE;
            end else begin
               row_in  = nrow_ext[RAW-1:0];
               rd_addr = nrow_ext[RAW-1:0];
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         peer_ff      <= '0;
         chunk_ff     <= '0;
         next_ff      <= '0;
         missing_ff   <= '0;
         tleft_ff     <= '0;
         tticks_ff    <= TIMEOUT_RESET;
         row_valid_ff <= '0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         peer_ff      <= peer_in;
         chunk_ff     <= chunk_in;
         next_ff      <= next_in;
         missing_ff   <= missing_in;
         tleft_ff     <= tleft_in;
         tticks_ff    <= tticks_in;
         row_valid_ff <= row_valid_in;
         done_ff      <= done_in;
      end
   end

   // Hold the position of the packet being marked
   always_ff @(posedge clock) begin
      row_ff <= row_in;
      off_ff <= off_in;
      adv_ff <= adv_in;
   end

   // Bitmap memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[row_ff] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
      rd_vld_ff  <= row_valid_ff[rd_addr];
   end

   // Next-expected and missing count never pass the session size
   assert property (@(posedge clock) disable iff (reset) next_ff <= NW'(PACKETS))
      else $error("next expected beyond session size");
   assert property (@(posedge clock) disable iff (reset) missing_ff <= NW'(PACKETS))
      else $error("missing count beyond session size");
   // A response is only produced when the response queue has room
   assert property (@(posedge clock) disable iff (reset) out_push |-> !out_full)
      else $error("response pushed into full queue");
   // Completion closes the session
   assert property (@(posedge clock) disable iff (reset)
      (out_push && out_rsp.chunk_done) |=> !active_ff)
      else $error("session still active after completion");
   // A scan only runs for an acknowledging data request
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> $past(state_ff == S_MARK || state_ff == S_SCAN))
      else $error("row scan entered without marking");

endmodule

FILE: hdl/chunk_receive_window_cumulative_ack.sv
// ---------------------------------------------------------------------------
// chunk_receive_window_cumulative_ack: chunk download receive tracker
// Tracks one chunk download session and produces a cumulative ACK per
// accepted data packet.
//
// Requests enter on req_push/req_full and are taken whenever req_full is low.
// Each request yields exactly one response, shown while rsp_empty is low and
// taken with rsp_pop. The timeout register is written on csr_valid; csr_ready
// is always high.
// A two-entry queue separates request intake from the session tracker, and a
// two-entry queue holds responses, so intake continues while responses wait.
// Start, tick and rejected data requests are answered from the idle state;
// their response is registered in the response queue. Accepted data reads
// its bitmap row (registered read), marks the packet, then walks further
// 32-packet bitmap rows while advancing next-expected past received packets.
// When the response queue is full the tracker holds and the request queue
// fills, raising req_full.
// Reset closes the session, clears the session registers and sets the timeout to 8
// ticks; the bitmap needs no clearing pass (row valid bits).
// ---------------------------------------------------------------------------
module chunk_receive_window_cumulative_ack #(
   parameter int PACKETS = crw_pkg::PACKETS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_peer,
   input  logic [11:0] req_chunk_index,
   input  logic [11:0] req_seq_num,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic        rsp_emit_ack,
   output logic [10:0] rsp_ack_num,
   output logic        rsp_chunk_done,
   output logic        rsp_timed_out,
   output logic [11:0] rsp_session_chunk,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_timeout_ticks
);

   import crw_pkg::*;

   item_type q_in_item, q_out_item;
   logic     q_push, q_full, q_pop, q_empty;
   rsp_type  r_in, r_out;
   logic     r_push, r_full;

   crw_front #(.PACKETS(PACKETS)) u_front (
      .req_push        (req_push),
      .req_cmd         (req_cmd),
      .req_peer        (req_peer),
      .req_chunk_index (req_chunk_index),
      .req_seq_num     (req_seq_num),
      .req_full        (req_full),
      .q_push          (q_push),
      .q_item          (q_in_item),
      .q_full          (q_full)
   );

   crw_fifo #(.WIDTH($bits(item_type)), .DEPTH(QUEUE_DEPTH)) u_req_q (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_in_item),
      .full     (q_full),
      .pop      (q_pop),
      .data_out (q_out_item),
      .empty    (q_empty)
   );

   crw_back #(.PACKETS(PACKETS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_timeout_ticks (csr_timeout_ticks),
      .in_item           (q_out_item),
      .in_empty          (q_empty),
      .in_pop            (q_pop),
      .out_full          (r_full),
      .out_push          (r_push),
      .out_rsp           (r_in)
   );

   crw_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (r_push),
      .data_in  (r_in),
      .full     (r_full),
      .pop      (rsp_pop),
      .data_out (r_out),
      .empty    (rsp_empty)
   );

   // Unpack the oldest response
   assign rsp_status        = r_out.status;
   assign rsp_emit_ack      = r_out.emit_ack;
   assign rsp_ack_num       = r_out.ack_num;
   assign rsp_chunk_done    = r_out.chunk_done;
   assign rsp_timed_out     = r_out.timed_out;
   assign rsp_session_chunk = r_out.session_chunk;

endmodule
